@@ rtl/core/iss_pkg.sv @@
// iss_pkg: shared types, codes and widths for the indexed sequence store
// no dependencies
package iss_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_state_t;

  // per-cycle command to the row of cells
  typedef struct packed {
    logic app_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

@@ rtl/core/iss_if.sv @@
// iss_if: valid/ready channel interfaces for command and result words
// depends on iss_pkg
interface iss_in_if;
  import iss_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] index;
  logic [VAL_W-1:0] value;

  modport source (output valid, cmd, index, value, input ready);
  modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface iss_out_if;
  import iss_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [VAL_W-1:0]    read_value;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, status, position, read_value, count, input ready);
  modport sink   (input valid, status, position, read_value, count, output ready);
endinterface

@@ rtl/core/iss_cell.sv @@
// iss_cell: one storage slot of the row, loads on append or takes its
// upper neighbour's value when an entry at or below it is removed
// depends on iss_pkg
module iss_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 7,
  parameter int CMP_W = 7
) (
  input  logic                     clk,
  input  iss_pkg::cell_ctrl_t      ctrl,
  input  logic [CNT_W-1:0]         cnt,
  input  logic [CMP_W-1:0]         idx,
  input  logic [iss_pkg::VAL_W-1:0] app_value,
  input  logic [iss_pkg::VAL_W-1:0] next_value,
  output logic [iss_pkg::VAL_W-1:0] value
);
  import iss_pkg::*;

  logic [VAL_W-1:0] value_r;
  logic [VAL_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.app_en && (cnt == CNT_W'(POS))) begin
      value_nxt = app_value;
    end else if (ctrl.shift_en && (idx <= CMP_W'(POS))) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

@@ rtl/core/iss_read_tree.sv @@
// iss_read_tree: picks the cell at the read index and ors the row down
// through a registered binary tree, one level per cycle
// depends on iss_pkg
module iss_read_tree #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF,
  parameter int CMP_W = 7
) (
  input  logic                      clk,
  input  logic [iss_pkg::VAL_W-1:0] values [DEPTH],
  input  logic [CMP_W-1:0]          idx,
  output logic [iss_pkg::VAL_W-1:0] root
);
  import iss_pkg::*;

  localparam int LVL   = $clog2(DEPTH);
  localparam int NLEAF = 1 << LVL;

  logic [VAL_W-1:0] node_r [1:2*NLEAF-1];

  for (genvar k = 0; k < NLEAF; k++) begin : g_leaf
    if (k < DEPTH) begin : g_used
      always_ff @(posedge clk) begin
        node_r[NLEAF+k] <= (idx == CMP_W'(k)) ? values[k] : '0;
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[NLEAF+k] <= '0;
      end
    end
  end

  for (genvar n = 1; n < NLEAF; n++) begin : g_node
    always_ff @(posedge clk) begin
      node_r[n] <= node_r[2*n] | node_r[2*n+1];
    end
  end

  assign root = node_r[1];

endmodule

@@ rtl/core/indexed_sequence_store_top.sv @@
// indexed_sequence_store_top: ordered store of 64-bit words held in a row of cells
// depends on iss_pkg, iss_if, iss_cell, iss_read_tree
//
// usage
//   in_ch carries one command word per handshake: append value at the tail,
//   remove the entry at index (later entries close up), or read at index.
//   out_ch returns exactly one result word per command: status, position
//   of an appended value, read data and the count after the command.
//   append, remove, errors and the unused code need no wait state: the
//   result is registered at the accepting edge, and a new command is taken
//   every cycle while out_ch keeps taking results.
//   a successful read waits in a read state while the registered or-tree
//   over the row fills, then loads the result register; in_ch is not ready
//   during that time.
//   the result register parts the two sides: a new command is taken in the
//   cycle that the waiting result is taken; while out_ch stalls in_ch holds
//   ready low and the result stays put.
//   rst_n (synchronous) empties the store and drops any pending result;
//   cell contents are not cleared, only the count.
module indexed_sequence_store_top #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  iss_in_if.sink    in_ch,
  iss_out_if.source out_ch
);
  import iss_pkg::*;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int LVL    = $clog2(DEPTH);
  localparam int WAIT_W = $clog2(LVL + 2);
  localparam logic [WAIT_W-1:0] WAIT_DONE = WAIT_W'(LVL + 1);

  fsm_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CMP_W-1:0]    idx_r, idx_nxt;
  logic [WAIT_W-1:0]   wait_cnt_r, wait_cnt_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [VAL_W-1:0]    out_rd_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                in_ready;
  logic                accept;
  logic                out_load;
  status_t             res_status;
  logic [POS_W-1:0]    res_pos;
  logic [VAL_W-1:0]    res_rd;
  cell_ctrl_t          ctrl;

  logic [CMP_W-1:0]    idx_cmp;
  logic                is_empty;
  logic                is_full;
  logic                out_of_range;

  logic [VAL_W-1:0]    cell_val [DEPTH];
  logic [VAL_W-1:0]    tree_root;

  assign idx_cmp      = CMP_W'(in_ch.index);
  assign is_empty     = (cnt_r == '0);
  assign is_full      = (cnt_r == CNT_W'(DEPTH));
  assign out_of_range = (idx_cmp >= CMP_W'(cnt_r));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    wait_cnt_nxt = wait_cnt_r;
    ctrl         = '0;
    out_load     = 1'b0;
    res_status   = ST_OK;
    res_pos      = '0;
    res_rd       = '0;
    in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
    accept       = in_ready && in_ch.valid;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = idx_cmp;
          case (in_ch.cmd)
            CMD_APPEND: begin
              out_load = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.app_en = 1'b1;
                res_pos     = POS_W'(cnt_r);
                cnt_nxt     = cnt_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              out_load = 1'b1;
              if (is_empty) begin
                res_status = ST_EMPTY;
              end else if (out_of_range) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.shift_en = 1'b1;
                cnt_nxt       = cnt_r - CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (is_empty) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else if (out_of_range) begin
                out_load   = 1'b1;
                res_status = ST_RANGE;
              end else begin
                state_nxt    = S_READ;
                wait_cnt_nxt = '0;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // root holds the selected cell once the tree has filled
        if (wait_cnt_r == WAIT_DONE) begin
          out_load  = 1'b1;
          res_rd    = tree_root;
          state_nxt = S_IDLE;
        end else begin
          wait_cnt_nxt = wait_cnt_r + WAIT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wait_cnt_r <= wait_cnt_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_pos_r    <= res_pos;
      out_rd_r     <= res_rd;
      out_count_r  <= COUNT_W'(cnt_nxt);
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] upper;
    if (k == DEPTH - 1) begin : g_last
      assign upper = cell_val[k];
    end else begin : g_mid
      assign upper = cell_val[k+1];
    end

    iss_cell #(
      .POS   (k),
      .CNT_W (CNT_W),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cnt        (cnt_r),
      .idx        (idx_cmp),
      .app_value  (in_ch.value),
      .next_value (upper),
      .value      (cell_val[k])
    );
  end

  iss_read_tree #(
    .DEPTH (DEPTH),
    .CMP_W (CMP_W)
  ) u_read_tree (
    .clk    (clk),
    .values (cell_val),
    .idx    (idx_r),
    .root   (tree_root)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.position   = out_pos_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.count      = out_count_r;

endmodule

@@ rtl/core/iss_checker.sv @@
// iss_checker: port-level checks on the indexed sequence store
// depends on iss_pkg; bound to indexed_sequence_store_top below
module iss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [iss_pkg::STATUS_W-1:0] out_status,
  input logic [iss_pkg::POS_W-1:0]    out_position,
  input logic [iss_pkg::VAL_W-1:0]    out_read_value,
  input logic [iss_pkg::COUNT_W-1:0]  out_count
);
  import iss_pkg::*;

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word pending after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // no command taken while an untaken result blocks the register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("command accepted over a stalled result");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_position == '0) && (out_read_value == '0))
    else $error("error result carries position or data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

endmodule

bind indexed_sequence_store_top iss_checker u_iss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_position   (out_ch.position),
  .out_read_value (out_ch.read_value),
  .out_count      (out_ch.count)
);
